// ===== design/assert_macros.svh =====
// shared assertion macros for the deque block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, codes and sizes shared by the bounded deque controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int DEPTH         = 256;
   localparam int HANDLE_BITS   = 32;
   localparam int ADDR_BITS     = $clog2(DEPTH);
   localparam int COUNT_BITS    = ADDR_BITS + 1;
   localparam int OP_BITS       = 3;
   localparam int POS_BITS      = 8;
   localparam int STATUS_BITS   = 2;
   localparam int CAP_BITS      = 9;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256);

   // register index, taken from the word address bit
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_MODE     = 1'b1;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_CLEAR      = 3'd5,
      OP_READ       = 3'd6
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISS    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ADDR_HEAD,
      ADDR_BACK,
      ADDR_TAIL,
      ADDR_PREV,
      ADDR_POS,
      ADDR_IDX,
      ADDR_IDX_NEXT
   } addr_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_INC,
      PTR_DEC,
      PTR_CLEAR
   } ptr_op_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_CLEAR,
      IDX_INC
   } idx_op_type;

   typedef struct packed {
      logic [CAP_BITS-1:0] capacity;
      logic                overwrite_mode;
   } cfg_type;

   typedef struct packed {
      logic         capture;
      logic         rd;
      logic         wr;
      logic         wr_from_ram;
      addr_sel_type addr;
      ptr_op_type   head_op;
      ptr_op_type   count_op;
      idx_op_type   idx_op;
      logic         set_status;
      status_type   status;
      logic         take_value;
      logic         take_drop;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               h_zero;
      logic               full;
      logic               over;
      logic               empty;
      logic               pos_oob;
      logic               mode;
      logic               match;
      logic               idx_last;
      logic               idx_next_last;
      logic               out_free;
   } stat_type;

endpackage

// ===== design/bdq_req_if.sv =====
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel of the deque: operation, handle and position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bdq_req_if import bdq_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [OP_BITS-1:0]     op;
   logic [HANDLE_BITS-1:0] handle;
   logic [POS_BITS-1:0]    position;

   modport source (output valid, output op, output handle, output position, input ready);
   modport sink (input valid, input op, input handle, input position, output ready);
endinterface

// ===== design/bdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel of the deque: status, values and occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bdq_rsp_if import bdq_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [HANDLE_BITS-1:0] value;
   logic                   dropped;
   logic [HANDLE_BITS-1:0] dropped_value;
   logic [COUNT_BITS-1:0]  occupancy;

   modport source (output valid, output status, output value, output dropped,
                   output dropped_value, output occupancy, input ready);
   modport sink (input valid, input status, input value, input dropped,
                 input dropped_value, input occupancy, output ready);
endinterface

// ===== design/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bdq_regs.sv =====
// ----------------------------------------------------------------------------
// bdq_regs
// Configuration registers (capacity, overwrite mode) behind an APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_regs import bdq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_CAPACITY: cfg_in.capacity       = csr_pwdata[CAP_BITS-1:0];
            REG_MODE:     cfg_in.overwrite_mode = csr_pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity       <= CAP_RESET;
         cfg_ff.overwrite_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CAPACITY: csr_prdata = CSR_DATA_BITS'(cfg_ff.capacity);
         REG_MODE:     csr_prdata = CSR_DATA_BITS'(cfg_ff.overwrite_mode);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/bdq_datapath.sv =====
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, head and count pointers, scan index and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_datapath import bdq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic [OP_BITS-1:0]     req_op,
   input  logic [HANDLE_BITS-1:0] req_handle,
   input  logic [POS_BITS-1:0]    req_position,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_value,
   output logic                   rsp_dropped,
   output logic [HANDLE_BITS-1:0] rsp_dropped_value,
   output logic [COUNT_BITS-1:0]  rsp_occupancy,
   input  cmd_type                cmd,
   output stat_type               stat
);

   // captured request
   logic [OP_BITS-1:0]     op_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [POS_BITS-1:0]    pos_ff;

   // pointers
   logic [ADDR_BITS-1:0]  head_ff, head_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ADDR_BITS-1:0]  idx_ff, idx_in;

   // pending result
   status_type             res_status_ff;
   logic [HANDLE_BITS-1:0] res_value_ff;
   logic                   res_drop_ff;
   logic [HANDLE_BITS-1:0] res_dval_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [HANDLE_BITS-1:0] rsp_value_ff;
   logic                   rsp_dropped_ff;
   logic [HANDLE_BITS-1:0] rsp_dval_ff;
   logic [COUNT_BITS-1:0]  rsp_occ_ff;

   logic [ADDR_BITS-1:0]   addr;
   logic [ADDR_BITS-1:0]   count_low;
   logic [HANDLE_BITS-1:0] ram_rdata;
   logic [HANDLE_BITS-1:0] ram_wdata;
   logic [COUNT_BITS-1:0]  lim;

   assign count_low = count_ff[ADDR_BITS-1:0];

   // physical slot; the ring wraps because the depth is a power of two
   always_comb begin
      case (cmd.addr)
         ADDR_HEAD:     addr = head_ff;
         ADDR_BACK:     addr = head_ff + count_low - ADDR_BITS'(1);
         ADDR_TAIL:     addr = head_ff + count_low;
         ADDR_PREV:     addr = head_ff - ADDR_BITS'(1);
         ADDR_POS:      addr = head_ff + ADDR_BITS'(pos_ff);
         ADDR_IDX:      addr = head_ff + idx_ff;
         ADDR_IDX_NEXT: addr = head_ff + idx_ff + ADDR_BITS'(1);
         default:       addr = head_ff;
      endcase
   end

   assign ram_wdata = cmd.wr_from_ram ? ram_rdata : handle_ff;

   bdq_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (addr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   // effective limit: zero acts as one, anything past the depth as the depth
   always_comb begin
      if (cfg.capacity == '0) begin
         lim = COUNT_BITS'(1);
      end else if (cfg.capacity > CAP_BITS'(DEPTH)) begin
         lim = COUNT_BITS'(DEPTH);
      end else begin
         lim = COUNT_BITS'(cfg.capacity);
      end
   end

   always_comb begin
      case (cmd.head_op)
         PTR_INC:   head_in = head_ff + ADDR_BITS'(1);
         PTR_DEC:   head_in = head_ff - ADDR_BITS'(1);
         PTR_CLEAR: head_in = '0;
         default:   head_in = head_ff;
      endcase
      case (cmd.count_op)
         PTR_INC:   count_in = count_ff + COUNT_BITS'(1);
         PTR_DEC:   count_in = count_ff - COUNT_BITS'(1);
         PTR_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
      case (cmd.idx_op)
         IDX_CLEAR: idx_in = '0;
         IDX_INC:   idx_in = idx_ff + ADDR_BITS'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_op;
         handle_ff    <= req_handle;
         pos_ff       <= req_position;
         res_value_ff <= '0;
         res_drop_ff  <= 1'b0;
         res_dval_ff  <= '0;
      end else begin
         if (cmd.take_value) begin
            res_value_ff <= ram_rdata;
         end
         if (cmd.take_drop) begin
            res_drop_ff <= 1'b1;
            res_dval_ff <= ram_rdata;
         end
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_value_ff   <= res_value_ff;
         rsp_dropped_ff <= res_drop_ff;
         rsp_dval_ff    <= res_dval_ff;
         rsp_occ_ff     <= count_ff;
      end
   end

   assign stat.op            = op_ff;
   assign stat.h_zero        = (handle_ff == '0);
   assign stat.full          = (count_ff >= lim);
   assign stat.over          = (count_ff > lim);
   assign stat.empty         = (count_ff == '0);
   assign stat.pos_oob       = (COUNT_BITS'(pos_ff) >= count_ff);
   assign stat.mode          = cfg.overwrite_mode;
   assign stat.match         = (ram_rdata == handle_ff);
   assign stat.idx_last      = (({1'b0, idx_ff} + COUNT_BITS'(1)) == count_ff);
   assign stat.idx_next_last = (({1'b0, idx_ff} + COUNT_BITS'(2)) == count_ff);
   assign stat.out_free      = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_dropped       = rsp_dropped_ff;
   assign rsp_dropped_value = rsp_dval_ff;
   assign rsp_occupancy     = rsp_occ_ff;

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_BITS'(DEPTH),
                 "occupancy beyond store depth")
   `ASSERT_IMPLY(a_one_port_op, clock, reset, cmd.wr, !cmd.rd,
                 "read and write issued together")

endmodule

// ===== design/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for deque operations: decode, memory steps, scan and compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_ctrl import bdq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DROP,
      S_VALUE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      is_back;

   assign is_back = (stat.op == OP_PUSH_BACK);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // no transfer is taken while reset is held
            req_ready = ~reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in       = S_RESP;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            case (op_type'(stat.op))
               OP_PUSH_BACK, OP_PUSH_FRONT: begin
                  if (stat.h_zero) begin
                     cmd.status = ST_INVALID;
                  end else if (stat.full) begin
                     if (!stat.mode || stat.over) begin
                        cmd.status = ST_FULL;
                     end else begin
                        // fetch the element at the opposite end first
                        cmd.rd   = 1'b1;
                        cmd.addr = is_back ? ADDR_HEAD : ADDR_BACK;
                        state_in = S_DROP;
                     end
                  end else begin
                     cmd.wr       = 1'b1;
                     cmd.count_op = PTR_INC;
                     if (is_back) begin
                        cmd.addr = ADDR_TAIL;
                     end else begin
                        cmd.addr    = ADDR_PREV;
                        cmd.head_op = PTR_DEC;
                     end
                  end
               end
               OP_POP_FRONT: begin
                  if (stat.empty) begin
                     cmd.status = ST_MISS;
                  end else begin
                     cmd.rd       = 1'b1;
                     cmd.addr     = ADDR_HEAD;
                     cmd.head_op  = PTR_INC;
                     cmd.count_op = PTR_DEC;
                     state_in     = S_VALUE;
                  end
               end
               OP_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.status = ST_MISS;
                  end else begin
                     cmd.rd       = 1'b1;
                     cmd.addr     = ADDR_BACK;
                     cmd.count_op = PTR_DEC;
                     state_in     = S_VALUE;
                  end
               end
               OP_REMOVE: begin
                  if (stat.h_zero) begin
                     cmd.status = ST_INVALID;
                  end else if (stat.empty) begin
                     cmd.status = ST_MISS;
                  end else begin
                     cmd.idx_op = IDX_CLEAR;
                     state_in   = S_SCAN_RD;
                  end
               end
               OP_CLEAR: begin
                  cmd.head_op  = PTR_CLEAR;
                  cmd.count_op = PTR_CLEAR;
               end
               OP_READ: begin
                  if (stat.pos_oob) begin
                     cmd.status = ST_MISS;
                  end else begin
                     cmd.rd   = 1'b1;
                     cmd.addr = ADDR_POS;
                     state_in = S_VALUE;
                  end
               end
               default: begin
                  cmd.status = ST_MISS;
               end
            endcase
         end
         S_DROP: begin
            // net count unchanged: one out at one end, one in at the other
            cmd.take_drop = 1'b1;
            cmd.wr        = 1'b1;
            cmd.addr      = is_back ? ADDR_TAIL : ADDR_PREV;
            cmd.head_op   = is_back ? PTR_INC : PTR_DEC;
            state_in      = S_RESP;
         end
         S_VALUE: begin
            cmd.take_value = 1'b1;
            state_in       = S_RESP;
         end
         S_SCAN_RD: begin
            cmd.rd   = 1'b1;
            cmd.addr = ADDR_IDX;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (stat.match) begin
               if (stat.idx_last) begin
                  cmd.count_op = PTR_DEC;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else if (stat.idx_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_MISS;
               state_in       = S_RESP;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            cmd.rd   = 1'b1;
            cmd.addr = ADDR_IDX_NEXT;
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move the next element down one slot
            cmd.wr          = 1'b1;
            cmd.wr_from_ram = 1'b1;
            cmd.addr        = ADDR_IDX;
            cmd.idx_op      = IDX_INC;
            if (stat.idx_next_last) begin
               cmd.count_op = PTR_DEC;
               state_in     = S_RESP;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_DECODE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && req_ready,
                state_ff == S_DECODE, "accepted transfer not decoded")
   `ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.rsp_load, stat.out_free,
                 "response loaded over a waiting transfer")

endmodule

// ===== design/bounded_deque_with_overwrite_unit.sv =====
// sequence from request transfer to response valid: push, clear and rejects pass through
// decode and response; pop, read and pipe-mode push with drop add a value or drop step;
// remove scans, then shifts the tail down through the single-port ring store
// a new request is taken in the cycle the previous response is registered, once the
// response output is free; no new request is taken while one is in progress
// reset clears pointers, response valid, sequencer state and config; the ring store is not cleared
// ----------------------------------------------------------------------------
// bounded_deque_with_overwrite_unit
// Bounded double-ended queue of handles with fixed and pipe overwrite modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_deque_with_overwrite_unit import bdq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   bdq_req_if.sink                  req,
   bdq_rsp_if.source                rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req.ready = req_ready;

   bdq_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bdq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_op            (req.op),
      .req_handle        (req.handle),
      .req_position      (req.position),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_status        (rsp.status),
      .rsp_value         (rsp.value),
      .rsp_dropped       (rsp.dropped),
      .rsp_dropped_value (rsp.dropped_value),
      .rsp_occupancy     (rsp.occupancy),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque: a directed table of corner
// operations, then randomized phases with sender gaps, receiver stalls and
// capacity/mode changes. Every response transfer is checked, field by field,
// against a table row or a deque model kept in step with accepted requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import bdq_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;
   localparam int RESET_CYCLES   = 9;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
   localparam int MAX_REPORTS    = 10;
   localparam int POOL_SIZE      = 16;

   typedef struct packed {
      status_type             status;
      logic [HANDLE_BITS-1:0] value;
      logic                   dropped;
      logic [HANDLE_BITS-1:0] dropped_value;
      logic [COUNT_BITS-1:0]  occupancy;
   } deque_result_type;

   typedef struct packed {
      logic                   is_cfg;
      logic                   cfg_sel;
      logic [CSR_DATA_BITS-1:0] cfg_data;
      logic [OP_BITS-1:0]     op;
      logic [HANDLE_BITS-1:0] handle;
      logic [POS_BITS-1:0]    position;
      logic                   typed;
      deque_result_type       want;
   } step_type;

   typedef struct packed {
      int send_idle;
      int recv_stall;
      int capacity;
      int pipe;
      int items;
      int push_pct;
      int hold;
   } phase_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   bdq_req_if req_if ();
   bdq_rsp_if rsp_if ();

   // expectation side channel, driven together with the request payload
   logic             req_typed;
   deque_result_type req_typed_result;

   // deque model state and register mirror
   logic [HANDLE_BITS-1:0] ring [DEPTH];
   logic [ADDR_BITS-1:0]   front_ptr;
   logic [COUNT_BITS-1:0]  held;
   logic [CAP_BITS-1:0]    cap_mirror;
   logic                   pipe_mirror;

   deque_result_type pending_results [$];
   int error_count;
   int quiet_cycles;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   int hold_served;

   bounded_deque_with_overwrite_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [ADDR_BITS-1:0] slot_of(input int logical);
      return front_ptr + ADDR_BITS'(logical);
   endfunction

   function automatic logic [HANDLE_BITS-1:0] take_front();
      logic [HANDLE_BITS-1:0] v;
      v = ring[front_ptr];
      front_ptr = front_ptr + 1'b1;
      held = held - 1'b1;
      return v;
   endfunction

   function automatic logic [HANDLE_BITS-1:0] take_back();
      logic [HANDLE_BITS-1:0] v;
      v = ring[slot_of(held - 1)];
      held = held - 1'b1;
      return v;
   endfunction

   function automatic deque_result_type predict_deque(input logic [OP_BITS-1:0] op_code,
                                                      input logic [HANDLE_BITS-1:0] h,
                                                      input logic [POS_BITS-1:0] pos);
      deque_result_type r;
      int lim;
      int i;
      int j;
      r = '0;
      r.status = ST_OK;
      lim = (cap_mirror == 0) ? 1 : ((cap_mirror > DEPTH) ? DEPTH : int'(cap_mirror));
      case (op_code)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (h == '0) begin
               r.status = ST_INVALID;
            end else if (held >= lim && (!pipe_mirror || held > lim)) begin
               r.status = ST_FULL;
            end else begin
               if (held >= lim) begin
                  // pipe mode: make room at the opposite end
                  r.dropped = 1'b1;
                  if (op_code == OP_PUSH_BACK) r.dropped_value = take_front();
                  else r.dropped_value = take_back();
               end
               if (op_code == OP_PUSH_BACK) begin
                  ring[slot_of(held)] = h;
               end else begin
                  front_ptr = front_ptr - 1'b1;
                  ring[front_ptr] = h;
               end
               held = held + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (held == 0) r.status = ST_MISS;
            else if (op_code == OP_POP_FRONT) r.value = take_front();
            else r.value = take_back();
         end
         OP_REMOVE: begin
            if (h == '0) begin
               r.status = ST_INVALID;
            end else begin
               r.status = ST_MISS;
               for (i = 0; i < held && r.status == ST_MISS; i++) begin
                  if (ring[slot_of(i)] == h) begin
                     // close the gap, keeping order
                     for (j = i; j + 1 < held; j++) ring[slot_of(j)] = ring[slot_of(j + 1)];
                     held = held - 1'b1;
                     r.status = ST_OK;
                  end
               end
            end
         end
         OP_CLEAR: begin
            held = '0;
            front_ptr = '0;
         end
         OP_READ: begin
            if (pos >= held) r.status = ST_MISS;
            else r.value = ring[slot_of(pos)];
         end
         default: r.status = ST_MISS;
      endcase
      r.occupancy = held;
      return r;
   endfunction

   task automatic log_mismatch(input string tag, input deque_result_type want,
                               input deque_result_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t %s: expected st=%0d val=%h drop=%0d dval=%h occ=%0d",
                  $realtime, tag, want.status, want.value, want.dropped, want.dropped_value,
                  want.occupancy);
         $display("%0t %s: got st=%0d val=%h drop=%0d dval=%h occ=%0d",
                  $realtime, tag, got.status, got.value, got.dropped, got.dropped_value,
                  got.occupancy);
      end
   endtask

   // scoreboard: predict on request transfer, compare on response transfer
   always @(posedge clock) begin : monitor
      deque_result_type want;
      deque_result_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            want = predict_deque(req_if.op, req_if.handle, req_if.position);
            if (req_typed) want = req_typed_result;
            pending_results.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.status = status_type'(rsp_if.status);
            got.value = rsp_if.value;
            got.dropped = rsp_if.dropped;
            got.dropped_value = rsp_if.dropped_value;
            got.occupancy = rsp_if.occupancy;
            if (pending_results.size() == 0) begin
               log_mismatch("unexpected response", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got.status != want.status || got.value != want.value ||
                   got.dropped != want.dropped || got.dropped_value != want.dropped_value ||
                   got.occupancy != want.occupancy)
                  log_mismatch("response mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bounded_deque_with_overwrite_unit regression: fail");
         $finish;
      end
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin : receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != hold_served) begin
            hold_served = hold_request;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input logic [OP_BITS-1:0] op, input logic [HANDLE_BITS-1:0] h,
                            input logic [POS_BITS-1:0] pos, input logic typed,
                            input deque_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.handle <= h;
      req_if.position <= pos;
      req_typed <= typed;
      req_typed_result <= want;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // stop offering and wait for every outstanding response
   task automatic quiesce();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic csr_write(input logic sel, input logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (sel == REG_CAPACITY) cap_mirror = data[CAP_BITS-1:0];
      else pipe_mirror = data[0];
      // bus returns to idle before the next access
      @(posedge clock);
   endtask

   function automatic step_type row_op(input logic [OP_BITS-1:0] op,
                                       input logic [HANDLE_BITS-1:0] h,
                                       input logic [POS_BITS-1:0] pos);
      step_type s;
      s = '0;
      s.op = op;
      s.handle = h;
      s.position = pos;
      return s;
   endfunction

   function automatic step_type row_chk(input logic [OP_BITS-1:0] op,
                                        input logic [HANDLE_BITS-1:0] h,
                                        input logic [POS_BITS-1:0] pos, input status_type st,
                                        input logic [COUNT_BITS-1:0] occ);
      step_type s;
      s = row_op(op, h, pos);
      s.typed = 1'b1;
      s.want.status = st;
      s.want.occupancy = occ;
      return s;
   endfunction

   function automatic step_type row_cfg(input logic sel,
                                        input logic [CSR_DATA_BITS-1:0] data);
      step_type s;
      s = '0;
      s.is_cfg = 1'b1;
      s.cfg_sel = sel;
      s.cfg_data = data;
      return s;
   endfunction

   initial begin : stimulus
      step_type directed [$];
      phase_type plan [7];
      logic [HANDLE_BITS-1:0] handle_pool [POOL_SIZE];
      logic [OP_BITS-1:0] op;
      logic [HANDLE_BITS-1:0] h;
      logic [POS_BITS-1:0] pos;
      int pick;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.op = '0;
      req_if.handle = '0;
      req_if.position = '0;
      req_typed = 1'b0;
      req_typed_result = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      front_ptr = '0;
      held = '0;
      cap_mirror = CAP_RESET;
      pipe_mirror = 1'b0;
      foreach (ring[k]) ring[k] = '0;
      error_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      hold_served = 0;
      foreach (handle_pool[k]) begin
         do handle_pool[k] = $urandom; while (handle_pool[k] == '0);
      end

      // empty queue, rejects and unknown op at reset settings
      directed.push_back(row_chk(OP_POP_FRONT, '0, '0, ST_MISS, 0));
      directed.push_back(row_chk(OP_POP_BACK, 32'hFFFF_FFFF, 8'hFF, ST_MISS, 0));
      directed.push_back(row_chk(OP_READ, '0, '0, ST_MISS, 0));
      directed.push_back(row_chk(OP_PUSH_BACK, '0, '0, ST_INVALID, 0));
      directed.push_back(row_chk(OP_PUSH_FRONT, '0, 8'hFF, ST_INVALID, 0));
      directed.push_back(row_chk(OP_REMOVE, '0, '0, ST_INVALID, 0));
      directed.push_back(row_chk(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, ST_MISS, 0));
      // push front from slot zero wraps the ring
      directed.push_back(row_chk(OP_PUSH_BACK, 32'hFFFF_FFFF, '0, ST_OK, 1));
      directed.push_back(row_chk(OP_PUSH_FRONT, 32'h0000_0001, '0, ST_OK, 2));
      directed.push_back(row_chk(OP_PUSH_BACK, 32'h8000_0000, '0, ST_OK, 3));
      directed.push_back(row_op(OP_READ, '0, 8'd0));
      directed.push_back(row_chk(OP_READ, '0, 8'hFF, ST_MISS, 3));
      directed.push_back(row_chk(OP_REMOVE, 32'h1234_5678, '0, ST_MISS, 3));
      directed.push_back(row_op(OP_REMOVE, 32'hFFFF_FFFF, '0));
      // full in fixed mode, then pipe mode drops from the opposite end
      directed.push_back(row_cfg(REG_CAPACITY, 32'd2));
      directed.push_back(row_chk(OP_PUSH_BACK, 32'hA5A5_A5A5, '0, ST_FULL, 2));
      directed.push_back(row_cfg(REG_MODE, 32'd1));
      directed.push_back(row_op(OP_PUSH_BACK, 32'h5A5A_5A5A, '0));
      directed.push_back(row_op(OP_PUSH_FRONT, 32'h0F0F_0F0F, '0));
      // capacity lowered below occupancy: push refused even in pipe mode
      directed.push_back(row_cfg(REG_CAPACITY, 32'd1));
      directed.push_back(row_chk(OP_PUSH_BACK, 32'h0000_0033, '0, ST_FULL, 2));
      directed.push_back(row_op(OP_POP_BACK, '0, '0));
      directed.push_back(row_op(OP_POP_FRONT, '0, '0));
      directed.push_back(row_chk(OP_POP_FRONT, '0, '0, ST_MISS, 0));
      directed.push_back(row_op(OP_PUSH_FRONT, 32'h0000_0077, '0));
      directed.push_back(row_op(OP_PUSH_BACK, 32'h0000_0088, '0));
      directed.push_back(row_chk(OP_CLEAR, '0, '0, ST_OK, 0));
      directed.push_back(row_chk(OP_READ, '0, '0, ST_MISS, 0));

      //            send rcv  cap  pipe items push hold
      plan[0] = '{  0,   0,   8,  0,   60,  50,  1};
      plan[1] = '{ 67,   0,   8,  1,   50,  50,  0};
      plan[2] = '{  0,  67,   1,  1,   40,  50,  0};
      plan[3] = '{ 31,  31, 256,  1,  290,  98,  0};
      plan[4] = '{  0,   0,   3,  0,   50,  40,  0};
      plan[5] = '{ 67,   0,  37,  1,   35,  55,  0};
      plan[6] = '{  0,  67, 200,  0,   35,  50,  0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         if (directed[k].is_cfg) begin
            quiesce();
            csr_write(directed[k].cfg_sel, directed[k].cfg_data);
         end else begin
            send_item(directed[k].op, directed[k].handle, directed[k].position,
                      directed[k].typed, directed[k].want);
         end
      end

      foreach (plan[p]) begin
         quiesce();
         csr_write(REG_CAPACITY, plan[p].capacity);
         csr_write(REG_MODE, plan[p].pipe);
         send_idle_pct = plan[p].send_idle;
         recv_stall_pct = plan[p].recv_stall;
         // long hold-off on the response side while requests keep coming
         if (plan[p].hold != 0) hold_request++;
         repeat (plan[p].items) begin
            pick = $urandom_range(99);
            if (pick < plan[p].push_pct) begin
               op = ($urandom_range(1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
               pick = $urandom_range(99);
               if (pick < 25) op = OP_POP_FRONT;
               else if (pick < 50) op = OP_POP_BACK;
               else if (pick < 68) op = OP_REMOVE;
               else if (pick < 71) op = OP_CLEAR;
               else if (pick < 97) op = OP_READ;
               else op = OP_UNUSED;
            end
            h = $urandom;
            pos = $urandom_range(255);
            pick = $urandom_range(99);
            if (pick < 2) h = '0;
            else if (op == OP_REMOVE && held != 0 && pick < 70)
               h = ring[slot_of($urandom_range(held - 1))];
            else if (pick < 50) h = handle_pool[$urandom_range(POOL_SIZE - 1)];
            if (op == OP_READ && held != 0 && $urandom_range(99) < 80)
               pos = $urandom_range(held - 1);
            send_item(op, h, pos, 1'b0, '0);
         end
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) log_mismatch("missing response", pending_results[0], '0);
      if (error_count == 0)
         $display("bounded_deque_with_overwrite_unit regression: pass");
      else
         $display("bounded_deque_with_overwrite_unit regression: fail");
      $finish;
   end

endmodule
